### sv/cell_balance_duty_controller_assert.svh
// Assertion macros shared by the RTL files.
`ifndef CELL_BALANCE_DUTY_CONTROLLER_ASSERT_SVH
`define CELL_BALANCE_DUTY_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
// pre and post hold in the same cycle
`define ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");
// pre in one cycle implies post in the next
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

### sv/cbdc_pkg.sv
package cbdc_pkg;

  localparam int CELL_IDX_W = 4;
  localparam int MV_W       = 16;
  localparam int TICK_W     = 16;
  localparam int MASK_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MV      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_MV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_PRESENT_MASK = 3'd5;

  localparam logic [MV_W-1:0]   THRESHOLD_RST  = 16'd4100;
  localparam logic [MV_W-1:0]   HYSTERESIS_RST = 16'd8;
  localparam logic [TICK_W-1:0] ON_TICKS_RST   = 16'd60;
  localparam logic [TICK_W-1:0] OFF_TICKS_RST  = 16'd30;
  localparam logic [MASK_W-1:0] PRESENT_RST    = 12'hFFF;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] cell_index;
    logic [MV_W-1:0]       cell_voltage_mv;
    logic                  open_wire_fault;
  } in_item_t;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] out_cell_index;
    logic                  bleed_enable;
  } out_item_t;

  typedef struct packed {
    logic              balance_enable;
    logic [MV_W-1:0]   threshold_mv;
    logic [MV_W-1:0]   hysteresis_mv;
    logic [TICK_W-1:0] on_ticks;
    logic [TICK_W-1:0] off_ticks;
    logic [MASK_W-1:0] cell_present_mask;
  } cfg_t;

endpackage

### sv/cell_balance_duty_controller.sv
// A request accepted into in_item_r has its result registered into out_item when the result
// register is free or being drained. Throughput: one request per cycle unless out_stall holds
// a full result register; a cell's state is read, updated and written back in the single
// compute stage, so back-to-back requests to the same cell chain correctly.
// Reset (rst_n low, synchronous): pipeline empty, all cells idle with zero countdown,
// configuration at its defaults with balancing disabled.
`include "cell_balance_duty_controller_assert.svh"

module cell_balance_duty_controller
  import cbdc_pkg::*;
#(
  parameter int NUM_CELLS = 12
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;
  logic      drive;

  cbdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // compute stage moves when the result register is free or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  cbdc_cell_state #(.NUM_CELLS(NUM_CELLS)) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance && in_valid_r),
    .item   (in_item_r),
    .cfg    (cfg),
    .drive  (drive)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_item_r.out_cell_index <= in_item_r.cell_index;
      out_item_r.bleed_enable   <= drive;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, in_valid_r && out_valid_r)
  `ASSERT_NEXT(a_compute_lands, clk, rst_n, advance && in_valid_r, out_valid_r)
  `ASSERT_NEXT(a_held_request_kept, clk, rst_n, in_stall, in_valid_r)

endmodule

### sv/cbdc_cfg_regs.sv
module cbdc_cfg_regs
  import cbdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.balance_enable    <= 1'b0;
      cfg_r.threshold_mv      <= THRESHOLD_RST;
      cfg_r.hysteresis_mv     <= HYSTERESIS_RST;
      cfg_r.on_ticks          <= ON_TICKS_RST;
      cfg_r.off_ticks         <= OFF_TICKS_RST;
      cfg_r.cell_present_mask <= PRESENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BALANCE_ENABLE:    cfg_r.balance_enable    <= cfg_wdata[0];
        REG_THRESHOLD_MV:      cfg_r.threshold_mv      <= cfg_wdata[MV_W-1:0];
        REG_HYSTERESIS_MV:     cfg_r.hysteresis_mv     <= cfg_wdata[MV_W-1:0];
        REG_ON_TICKS:          cfg_r.on_ticks          <= cfg_wdata[TICK_W-1:0];
        REG_OFF_TICKS:         cfg_r.off_ticks         <= cfg_wdata[TICK_W-1:0];
        REG_CELL_PRESENT_MASK: cfg_r.cell_present_mask <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/cbdc_cell_state.sv
`include "cell_balance_duty_controller_assert.svh"

module cbdc_cell_state
  import cbdc_pkg::*;
#(
  parameter int NUM_CELLS = 12
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     upd_en,
  input  in_item_t item,
  input  cfg_t     cfg,
  output logic     drive
);

  localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  logic              act_r [NUM_CELLS];
  logic [TICK_W-1:0] cd_r  [NUM_CELLS];

  logic [5:0]        idx_wide;
  logic [IDX_W-1:0]  cell_sel;
  logic              in_range;
  logic              present;
  logic [MASK_W-1:0] mask_shift;
  logic [MV_W:0]     limit;
  logic              act_rd;
  logic [TICK_W-1:0] cd_rd;
  logic              act_nxt;
  logic [TICK_W-1:0] cd_nxt;
  logic              wr_en;

  assign idx_wide   = 6'(item.cell_index);
  assign cell_sel   = idx_wide[IDX_W-1:0];
  assign in_range   = idx_wide < 6'(NUM_CELLS);
  // cells past the mask width shift in zeros and read as absent
  assign mask_shift = cfg.cell_present_mask >> item.cell_index;
  assign present    = mask_shift[0];
  assign limit      = {1'b0, cfg.threshold_mv} + {1'b0, cfg.hysteresis_mv};
  assign act_rd     = in_range ? act_r[cell_sel] : 1'b0;
  assign cd_rd      = in_range ? cd_r[cell_sel] : '0;

  always_comb begin
    act_nxt = act_rd;
    cd_nxt  = cd_rd;
    drive   = 1'b0;
    wr_en   = 1'b0;
    if (cfg.balance_enable && in_range) begin
      wr_en = upd_en;
      if (cd_rd != '0) begin
        cd_nxt = cd_rd - 16'd1;
        drive  = act_rd;
      end else if (act_rd) begin
        act_nxt = 1'b0;
        cd_nxt  = cfg.off_ticks;
      end else if ({1'b0, item.cell_voltage_mv} > limit) begin
        act_nxt = 1'b1;
        cd_nxt  = cfg.on_ticks;
        drive   = 1'b1;
      end
      if (!present) drive = 1'b0;
      if (item.open_wire_fault) begin
        drive   = 1'b0;
        act_nxt = 1'b0;
        cd_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        act_r[i] <= 1'b0;
        cd_r[i]  <= '0;
      end
    end else if (wr_en) begin
      act_r[cell_sel] <= act_nxt;
      cd_r[cell_sel]  <= cd_nxt;
    end
  end

  `ASSERT_NOW(a_drive_gated, clk, rst_n, drive,
    cfg.balance_enable && present && in_range && !item.open_wire_fault)
  `ASSERT_NOW(a_no_write_when_off, clk, rst_n, !cfg.balance_enable, !wr_en)

endmodule
